FILE: hdl/assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)

`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: hdl/swc_pkg.sv
package swc_pkg;

    localparam int SYNC_BITS_DEF = 32;
    localparam int WORD_W        = 32;
    localparam int THR_W         = 5;
    localparam int PAYLOAD_W     = 16;
    localparam int SKIP_W        = 19;
    localparam int SAMPLE_W      = 8;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_BYTES   = 2'd3;

    typedef struct packed {
        logic shift;
        logic ref_bit;
        logic mask_bit;
    } cell_ctl_t;

endpackage

FILE: hdl/swc_cell.sv
module swc_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  swc_pkg::cell_ctl_t ctl,
    input  logic              bit_in,
    output logic              bit_q,
    output logic              diff
);

    logic bit_reg;
    logic bit_next;

    assign bit_next = ctl.shift ? bit_in : bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    // mismatch of the bit entering this cell
    assign diff  = (bit_in ^ ctl.ref_bit) & ctl.mask_bit;
    assign bit_q = bit_reg;

endmodule

FILE: hdl/swc_popcount.sv
module swc_popcount #(
    parameter int N = swc_pkg::SYNC_BITS_DEF
)
(
    input  logic [N-1:0]             bits,
    output logic [$clog2(N+1)-1:0]   count
);

    localparam int LOG_P  = $clog2(N);
    localparam int P      = 1 << LOG_P;
    localparam int NODE_W = $clog2(P + 1);
    localparam int OUT_W  = $clog2(N + 1);

    logic [NODE_W-1:0] node [1:2*P-1];

    for (genvar j = 0; j < P; j++)
    begin : g_leaf
        if (j < N)
        begin : g_used
            assign node[P+j] = NODE_W'(bits[j]);
        end
        else
        begin : g_pad
            assign node[P+j] = '0;
        end
    end

    for (genvar i = 1; i < P; i++)
    begin : g_sum
        assign node[i] = node[2*i] + node[2*i+1];
    end

    assign count = node[1][OUT_W-1:0];

endmodule

FILE: hdl/sync_word_correlator_unit.sv
// Frame sync word correlator. Each item carries one sample byte that comes back
// unchanged as one result item; bit 0 of the byte is shifted through a row of
// SYNC_BITS cells, each holding one history bit and flagging whether the bit
// entering it differs from its sync word bit under the compare mask. Once the
// row is full, the masked mismatch count (adder tree) is compared with
// error_threshold: at most the threshold gives sync_found, at least SYNC_BITS
// minus the threshold gives sync_inverted, and either match makes the next
// payload_bytes*8 items pass by without entering the row. One item is taken
// every cycle while in_stall is low; the result appears next cycle from the
// output register; in_stall follows out_stall only while it holds an item.
// Registers must be written only while no item is in flight; not enforced.
`include "assert_macros.svh"

module sync_word_correlator_unit #(
    parameter int SYNC_BITS = swc_pkg::SYNC_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [swc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swc_pkg::WORD_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [swc_pkg::SAMPLE_W-1:0]    sample_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [swc_pkg::SAMPLE_W-1:0]    sample_out,
    output logic                            sync_found,
    output logic                            sync_inverted
);

    localparam int CNT_W = $clog2(SYNC_BITS + 1);
    localparam int SUM_W = (CNT_W > swc_pkg::THR_W ? CNT_W : swc_pkg::THR_W) + 1;

    logic [swc_pkg::WORD_W-1:0]    sync_word_reg;
    logic [swc_pkg::WORD_W-1:0]    mask_reg;
    logic [swc_pkg::THR_W-1:0]     thr_reg;
    logic [swc_pkg::PAYLOAD_W-1:0] payload_reg;

    logic [CNT_W-1:0]              fill_reg;
    logic [CNT_W-1:0]              fill_next;
    logic [swc_pkg::SKIP_W-1:0]    skip_reg;
    logic [swc_pkg::SKIP_W-1:0]    skip_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [swc_pkg::SAMPLE_W-1:0]  sample_reg;
    logic                          found_reg;
    logic                          inv_reg;

    logic                          in_accept;
    logic                          shift;
    logic                          compare;
    logic                          found_next;
    logic                          inv_next;
    logic [SYNC_BITS-1:0]          hist;
    logic [SYNC_BITS-1:0]          diff;
    logic [CNT_W-1:0]              nwrong;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg <= '0;
            mask_reg      <= '1;
            thr_reg       <= '0;
            payload_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                swc_pkg::CFG_SYNC_WORD:       sync_word_reg <= cfg_data;
                swc_pkg::CFG_COMPARE_MASK:    mask_reg      <= cfg_data;
                swc_pkg::CFG_ERROR_THRESHOLD: thr_reg       <= cfg_data[swc_pkg::THR_W-1:0];
                swc_pkg::CFG_PAYLOAD_BYTES:   payload_reg   <= cfg_data[swc_pkg::PAYLOAD_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign shift     = in_accept & (skip_reg == '0);

    // cell row, newest bit in cell 0
    for (genvar i = 0; i < SYNC_BITS; i++)
    begin : g_cell
        swc_pkg::cell_ctl_t ctl;
        logic               bit_in;

        assign ctl.shift    = shift;
        assign ctl.ref_bit  = sync_word_reg[i];
        assign ctl.mask_bit = mask_reg[i];

        if (i == 0)
        begin : g_head
            assign bit_in = sample_in[0];
        end
        else
        begin : g_link
            assign bit_in = hist[i-1];
        end

        swc_cell u_cell
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .bit_in (bit_in),
            .bit_q  (hist[i]),
            .diff   (diff[i])
        );
    end

    swc_popcount #(
        .N (SYNC_BITS)
    ) u_popcount
    (
        .bits  (diff),
        .count (nwrong)
    );

    assign compare    = shift & (fill_reg >= CNT_W'(SYNC_BITS - 1));
    assign found_next = compare & (SUM_W'(nwrong) <= SUM_W'(thr_reg));
    assign inv_next   = compare & ~found_next
                      & ((SUM_W'(nwrong) + SUM_W'(thr_reg)) >= SUM_W'(SYNC_BITS));

    always_comb
    begin
        fill_next = fill_reg;
        if (shift && (fill_reg != CNT_W'(SYNC_BITS)))
        begin
            fill_next = fill_reg + CNT_W'(1);
        end

        skip_next = skip_reg;
        if (in_accept)
        begin
            if (skip_reg != '0)
            begin
                skip_next = skip_reg - swc_pkg::SKIP_W'(1);
            end
            else if (found_next || inv_next)
            begin
                skip_next = swc_pkg::SKIP_W'({payload_reg, 3'b000});
            end
        end

        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg & out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            skip_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample_in;
            found_reg  <= found_next;
            inv_reg    <= inv_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_reg;
    assign sync_found    = found_reg;
    assign sync_inverted = inv_reg;

    `ASSERT_NEVER(a_one_polarity, out_valid_reg && found_reg && inv_reg, "both sync flags set")
    `ASSERT_CLK(a_flag_full, (out_valid_reg && (found_reg || inv_reg)) |-> (fill_reg == CNT_W'(SYNC_BITS)), "sync flagged before row full")
    `ASSERT_CLK(a_skip_load, (in_accept && (found_next || inv_next)) |=> (skip_reg == swc_pkg::SKIP_W'({$past(payload_reg), 3'b000})), "payload skip not loaded")
    `ASSERT_CLK(a_skip_count, (in_accept && (skip_reg != '0)) |=> (skip_reg == $past(skip_reg) - swc_pkg::SKIP_W'(1)), "payload skip not counting down")

endmodule
